### hdl/mei_pkg.sv
// Shared types and constants for the escape-time iteration block.
`timescale 1ns / 1ps

package mei_pkg;

	// Fixed number format of c and z: signed, DATA_WIDTH bits, FRAC_BITS fraction bits
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 28;
	localparam int ITER_WIDTH = 10;

	localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = 10'd100;

	// One input beat: the point c
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] c_real;
		logic signed [DATA_WIDTH-1:0] c_imag;
	} mei_in_t;

	// One result beat
	typedef struct packed {
		logic [ITER_WIDTH-1:0] iteration_count;
		logic                  escaped;
	} mei_out_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AB,
		ST_UPD,
		ST_RR,
		ST_II,
		ST_CHK
	} mei_state_t;

	// Operand pair for the shared multiplier
	typedef enum logic [1:0] {
		MUL_AB,
		MUL_RR,
		MUL_II
	} mei_mul_sel_t;

	// Sequencer to datapath
	typedef struct packed {
		logic         load;
		logic         upd_z;
		logic         ld_rr;
		logic         ld_ii;
		mei_mul_sel_t mul_sel;
	} mei_ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic esc_mag;
		logic esc_sum;
	} mei_stat_t;

endpackage

### hdl/mei_datapath.sv
// Datapath: shared signed multiplier, z registers, update and escape tests.
`timescale 1ns / 1ps

module mei_datapath (
	input  logic               clk,
	input  mei_pkg::mei_in_t   point,
	input  mei_pkg::mei_ctrl_t ctrl,
	output mei_pkg::mei_stat_t stat
);

	localparam int W  = mei_pkg::DATA_WIDTH;
	localparam int F  = mei_pkg::FRAC_BITS;
	localparam int ZW = W + 2;
	localparam int PW = 2 * W;

	localparam logic signed [ZW-1:0] TWO_POS = ZW'(1) <<< (F + 1);
	localparam logic signed [ZW-1:0] TWO_NEG = -TWO_POS;
	localparam logic [PW:0]          SQ_LIM  = (PW + 1)'(1) << (2 * F + 2);

	logic signed [W-1:0]  cr_q, ci_q, zr_q, zi_q;
	logic signed [PW-1:0] rr_q, ii_q, p_q;
	logic signed [W-1:0]  mul_a, mul_b;
	logic signed [PW-1:0] diff, re_sh, im_sh;
	logic signed [ZW-1:0] nr, ni;
	logic [PW:0]          sq_sum;

	// Pick the operand pair for the shared multiplier
	always_comb begin
		unique case (ctrl.mul_sel)
			mei_pkg::MUL_AB: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			mei_pkg::MUL_RR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			mei_pkg::MUL_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
	end

	// Form the next z from the stored squares and the registered cross product
	always_comb begin
		diff  = rr_q - ii_q;
		re_sh = diff >>> F;
		im_sh = (p_q <<< 1) >>> F;
		nr    = $signed(re_sh[ZW-1:0]) + $signed({{(ZW - W){cr_q[W-1]}}, cr_q});
		ni    = $signed(im_sh[ZW-1:0]) + $signed({{(ZW - W){ci_q[W-1]}}, ci_q});
	end

	// Escape by a component beyond 2, or by |z|^2 beyond 4 (p_q holds zi^2 here)
	always_comb begin
		sq_sum       = {1'b0, rr_q} + {1'b0, p_q};
		stat.esc_mag = (nr > TWO_POS) || (nr < TWO_NEG) || (ni > TWO_POS) || (ni < TWO_NEG);
		stat.esc_sum = sq_sum > SQ_LIM;
	end

	// Advance the working registers
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (ctrl.load) begin
			cr_q <= point.c_real;
			ci_q <= point.c_imag;
			zr_q <= '0;
			zi_q <= '0;
			rr_q <= '0;
			ii_q <= '0;
		end else begin
			if (ctrl.upd_z) begin
				zr_q <= nr[W-1:0];
				zi_q <= ni[W-1:0];
			end
			if (ctrl.ld_rr) begin
				rr_q <= p_q;
			end
			if (ctrl.ld_ii) begin
				ii_q <= p_q;
			end
		end
	end

endmodule

### hdl/mei_seq.sv
// Sequencer: steps the shared multiplier through each iteration and counts iterations.
`timescale 1ns / 1ps

module mei_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mei_pkg::ITER_WIDTH-1:0]  max_iterations,
	input  mei_pkg::mei_stat_t              stat,
	output mei_pkg::mei_ctrl_t              ctrl,
	output logic                            busy,
	output logic                            done,
	output mei_pkg::mei_out_t               result
);

	localparam int IW = mei_pkg::ITER_WIDTH;

	mei_pkg::mei_state_t state_q, state_d;
	logic [IW-1:0]       iter_q;
	logic                iter_inc;
	logic                fin, fin_esc;
	logic                last_iter;
	logic                done_q;
	mei_pkg::mei_out_t   result_q;

	assign last_iter = ({1'b0, iter_q} + (IW + 1)'(1)) == {1'b0, max_iterations};

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mei_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decide next state and drive datapath controls
	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		ctrl.mul_sel = mei_pkg::MUL_AB;
		iter_inc     = 1'b0;
		fin          = 1'b0;
		fin_esc      = 1'b0;
		unique case (state_q)
			mei_pkg::ST_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					if (max_iterations == '0) begin
						fin = 1'b1;
					end else begin
						state_d = mei_pkg::ST_AB;
					end
				end
			end
			mei_pkg::ST_AB: begin
				state_d = mei_pkg::ST_UPD;
			end
			mei_pkg::ST_UPD: begin
				ctrl.upd_z = 1'b1;
				if (stat.esc_mag) begin
					fin     = 1'b1;
					fin_esc = 1'b1;
					state_d = mei_pkg::ST_IDLE;
				end else begin
					state_d = mei_pkg::ST_RR;
				end
			end
			mei_pkg::ST_RR: begin
				ctrl.mul_sel = mei_pkg::MUL_RR;
				state_d      = mei_pkg::ST_II;
			end
			mei_pkg::ST_II: begin
				ctrl.mul_sel = mei_pkg::MUL_II;
				ctrl.ld_rr   = 1'b1;
				state_d      = mei_pkg::ST_CHK;
			end
			mei_pkg::ST_CHK: begin
				// cross product for the next iteration is formed in this cycle
				ctrl.ld_ii = 1'b1;
				priority if (stat.esc_sum) begin
					fin     = 1'b1;
					fin_esc = 1'b1;
					state_d = mei_pkg::ST_IDLE;
				end else if (last_iter) begin
					fin     = 1'b1;
					state_d = mei_pkg::ST_IDLE;
				end else begin
					iter_inc = 1'b1;
					state_d  = mei_pkg::ST_UPD;
				end
			end
			default: begin
				state_d = mei_pkg::ST_IDLE;
			end
		endcase
	end

	// Count iterations and pulse the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
			if (ctrl.load) begin
				iter_q <= '0;
			end else if (iter_inc) begin
				iter_q <= iter_q + IW'(1);
			end
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (fin) begin
			result_q.escaped         <= fin_esc;
			result_q.iteration_count <= fin_esc ? iter_q : '0;
		end
	end

	assign busy   = state_q != mei_pkg::ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

### hdl/mandelbrot_escape_iteration_top.sv
// Top level of the escape-time iteration block: config register, sequencer, datapath.
`timescale 1ns / 1ps

// Escape-time iteration for one complex point c per command.
// Input: assert start with point (c_real, c_imag, signed Q4.28); the beat is taken
// at an edge where start is high and busy is low. busy stays high while the point
// is worked on, and no new point is taken until it drops.
// Output: done is high for exactly one cycle with result (iteration_count, escaped).
// The receiver cannot stall; the beat is gone after that cycle.
// Configuration: cfg_we with cfg_wdata writes max_iterations (reset value 100).
// Write it only while the block is idle.
// Schedule: one shared signed 32x32 multiplier forms z_re*z_im, z_re^2 and z_im^2 in
// turn, so one iteration takes four sequencer steps. A point that escapes by a
// component beyond 2 is caught in the update step, and by |z|^2 beyond 4 in the
// check step; a point that does not escape runs max_iterations iterations, and
// max_iterations = 0 gives done without running any iteration.
// busy drops in the cycle done is shown, so the next point can be taken then.
// Reset: arst_n clears the sequencer to idle, drops done and restores the limit.

module mandelbrot_escape_iteration_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  mei_pkg::mei_in_t               point,
	output logic                           busy,
	output logic                           done,
	output mei_pkg::mei_out_t              result,
	input  logic                           cfg_we,
	input  logic [mei_pkg::ITER_WIDTH-1:0] cfg_wdata
);

	logic [mei_pkg::ITER_WIDTH-1:0] max_iter_q;
	mei_pkg::mei_ctrl_t             ctrl;
	mei_pkg::mei_stat_t             stat;

	// Hold the iteration limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= mei_pkg::MAX_ITER_RESET;
		end else if (cfg_we) begin
			max_iter_q <= cfg_wdata;
		end
	end

	mei_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.max_iterations (max_iter_q),
		.stat           (stat),
		.ctrl           (ctrl),
		.busy           (busy),
		.done           (done),
		.result         (result)
	);

	mei_datapath u_datapath (
		.clk   (clk),
		.point (point),
		.ctrl  (ctrl),
		.stat  (stat)
	);

	// A result beat only appears once the sequencer is back at idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// A point that did not escape reports index zero
	a_no_esc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.escaped) |-> (result.iteration_count == '0))
		else $error("nonzero count without escape");

	// An accepted point with a nonzero limit starts work
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (max_iter_q != '0)) |=> busy)
		else $error("accepted point did not start");

	// Work begins only from an accepted command
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without start");

endmodule

### sim/mandelbrot_escape_iteration_top_tb.sv
// Self-checking testbench for the escape-time iteration block.
`timescale 1ns / 1ps

module mandelbrot_escape_iteration_top_tb;

	localparam int DW = mei_pkg::DATA_WIDTH;
	localparam int FB = mei_pkg::FRAC_BITS;
	localparam int IW = mei_pkg::ITER_WIDTH;
	localparam int ZW = 2 * DW;

	// Q4.28 values used by the directed points
	localparam logic signed [DW-1:0] Q_ONE  = 32'sd268435456;
	localparam logic signed [DW-1:0] Q_TWO  = 32'sd536870912;
	localparam logic signed [DW-1:0] Q_MAXV = 32'sh7FFFFFFF;
	localparam logic signed [DW-1:0] Q_MINV = 32'sh80000000;

	// Kinds of pending stimulus
	typedef enum logic [1:0] {
		CMD_POINT,
		CMD_LIMIT,
		CMD_DRAIN
	} stim_kind_t;

	typedef struct {
		stim_kind_t        kind;
		mei_pkg::mei_in_t  point;
		logic [IW-1:0]     limit;
	} stim_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	mei_pkg::mei_in_t  point     = '0;
	logic              cfg_we    = 1'b0;
	logic [IW-1:0]     cfg_wdata = '0;
	logic              busy;
	logic              done;
	mei_pkg::mei_out_t result;

	stim_t             pending[$];
	mei_pkg::mei_out_t escape_q[$];
	logic [IW-1:0]     limit_now   = mei_pkg::MAX_ITER_RESET;
	logic              point_taken = 1'b0;
	int                total_points = 0;
	int                points_sent  = 0;
	int                points_seen  = 0;
	int                points_out   = 0;
	int                limits_set   = 0;
	int                errors       = 0;

	mandelbrot_escape_iteration_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.point     (point),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Escape index of point p under the given limit, exact fixed-point iteration
	function automatic mei_pkg::mei_out_t predict_escape(mei_pkg::mei_in_t p,
	                                                     logic [IW-1:0] limit);
		logic signed [ZW-1:0] cr;
		logic signed [ZW-1:0] ci;
		logic signed [ZW-1:0] zr;
		logic signed [ZW-1:0] zi;
		logic signed [ZW-1:0] two;
		logic signed [ZW-1:0] four;
		mei_pkg::mei_out_t    r;
		cr   = $signed(p.c_real);
		ci   = $signed(p.c_imag);
		zr   = '0;
		zi   = '0;
		two  = ZW'(1) <<< (FB + 1);
		four = ZW'(1) <<< (2 * FB + 2);
		r    = '0;
		for (int k = 0; k < limit; k++) begin
			logic signed [ZW-1:0] nr;
			logic signed [ZW-1:0] ni;
			// floor shift back to FRAC_BITS, then add c exactly
			nr = ((zr * zr - zi * zi) >>> FB) + cr;
			ni = (((zr * zi) <<< 1) >>> FB) + ci;
			zr = nr;
			zi = ni;
			// a component beyond 2 escapes before its square is formed
			if (zr > two || zr < -two || zi > two || zi < -two ||
			    zr * zr + zi * zi > four) begin
				r.iteration_count = IW'(k);
				r.escaped         = 1'b1;
				return r;
			end
		end
		return r;
	endfunction

	// Pick one component near a corner of the number range
	function automatic logic signed [DW-1:0] edge_value();
		case ($urandom_range(0, 9))
			0: return Q_MAXV;
			1: return Q_MINV;
			2: return Q_TWO;
			3: return -Q_TWO;
			4: return Q_TWO + 1;
			5: return -Q_TWO - 1;
			6: return 32'sd1;
			7: return -32'sd1;
			8: return Q_ONE;
			default: return '0;
		endcase
	endfunction

	task automatic add_point(input logic signed [DW-1:0] re,
	                         input logic signed [DW-1:0] im);
		stim_t s;
		s.kind         = CMD_POINT;
		s.point.c_real = re;
		s.point.c_imag = im;
		s.limit        = '0;
		pending.push_back(s);
		total_points++;
	endtask

	task automatic add_limit(input logic [IW-1:0] v);
		stim_t s;
		s.kind  = CMD_LIMIT;
		s.point = '0;
		s.limit = v;
		pending.push_back(s);
	endtask

	task automatic add_drain();
		stim_t s;
		s.kind  = CMD_DRAIN;
		s.point = '0;
		s.limit = '0;
		pending.push_back(s);
	endtask

	// Mostly points near the set, where orbits run long; the rest wide noise and corners
	task automatic add_random_points(input int n);
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		int                   pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				re = -32'sd563714457 + int'($urandom_range(0, 724775731));
				im = -32'sd322122547 + int'($urandom_range(0, 644245094));
			end else if (pick < 70) begin
				re = int'($urandom_range(0, 1 << 30)) - (1 << 29);
				im = int'($urandom_range(0, 1 << 30)) - (1 << 29);
			end else if (pick < 90) begin
				re = $urandom;
				im = $urandom;
			end else begin
				re = edge_value();
				im = edge_value();
			end
			add_point(re, im);
		end
	endtask

	// Drive one beat or one register write per free cycle, change at falling edge
	always @(negedge clk) begin : drive
		logic             nx_start;
		logic             nx_we;
		mei_pkg::mei_in_t nx_point;
		logic [IW-1:0]    nx_wdata;
		int               idle_pct;
		nx_start = start;
		nx_we    = 1'b0;
		nx_point = point;
		nx_wdata = cfg_wdata;
		if (points_sent * 3 < total_points)
			idle_pct = 11;
		else if (points_sent * 3 < total_points * 2)
			idle_pct = 76;
		else
			idle_pct = 0;
		// hold start until the beat is taken
		if (arst_n && !(start && !point_taken)) begin
			nx_start = 1'b0;
			if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				case (pending[0].kind)
					CMD_POINT: begin
						nx_start = 1'b1;
						nx_point = pending[0].point;
						void'(pending.pop_front());
						points_sent++;
					end
					CMD_LIMIT: begin
						if (escape_q.size() == 0 && !busy) begin
							nx_we    = 1'b1;
							nx_wdata = pending[0].limit;
							void'(pending.pop_front());
						end
					end
					default: begin
						if (escape_q.size() == 0 && !busy)
							void'(pending.pop_front());
					end
				endcase
			end
		end
		start     <= nx_start;
		cfg_we    <= nx_we;
		point     <= nx_point;
		cfg_wdata <= nx_wdata;
	end

	// Check results, track the limit and predict each accepted beat
	always @(posedge clk) begin : observe
		mei_pkg::mei_out_t want;
		if (arst_n) begin
			if (done) begin
				if (escape_q.size() == 0) begin
					$error("result beat with no point outstanding: count %0d escaped %0b",
					       result.iteration_count, result.escaped);
					errors++;
				end else begin
					want = escape_q.pop_front();
					points_seen++;
					if (!want.escaped)
						points_out++;
					if (result.iteration_count !== want.iteration_count) begin
						$error("iteration_count: expected %0d, actual %0d",
						       want.iteration_count, result.iteration_count);
						errors++;
					end
					if (result.escaped !== want.escaped) begin
						$error("escaped: expected %0b, actual %0b", want.escaped, result.escaped);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				limit_now = cfg_wdata;
				limits_set++;
			end
			if (start && !busy)
				escape_q.push_back(predict_escape(point, limit_now));
		end
		point_taken <= arst_n && start && !busy;
	end

	// Reset once at the start
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Fill the stimulus and wait for the run to drain
	initial begin
		// corners, exact boundary values and slow orbits at the reset limit
		add_point('0, '0);
		add_point(Q_MAXV, Q_MAXV);
		add_point(Q_MINV, Q_MINV);
		add_point(Q_MAXV, '0);
		add_point('0, Q_MINV);
		add_point(Q_MINV, '0);
		add_point(Q_TWO, '0);
		add_point(-Q_TWO, '0);
		add_point('0, Q_TWO);
		add_point('0, -Q_TWO);
		add_point(Q_TWO + 1, '0);
		add_point('0, -Q_TWO - 1);
		add_point(32'sd67108864, '0);
		add_point(32'sd69793218, '0);
		add_point(-Q_ONE, '0);
		add_point('0, Q_ONE);
		add_point(-32'sd1, -32'sd1);
		add_point(32'sd402653184, 32'sd402653184);
		add_point(32'sd379625062, 32'sd379625062);
		add_point(-32'sd201326592, 32'sd26843546);
		// zero limit runs no iteration at all
		add_limit('0);
		add_point(Q_ONE * 3, '0);
		add_point('0, '0);
		add_limit(10'd1);
		add_random_points(150);
		add_limit(10'd1023);
		add_point(-Q_ONE, '0);
		add_point(32'sd67108864, '0);
		add_random_points(15);
		add_limit(10'd5);
		add_random_points(150);
		add_drain();
		add_random_points(150);
		add_limit(10'd255);
		add_random_points(100);
		add_limit(mei_pkg::MAX_ITER_RESET);
		add_random_points(400);
		add_limit(IW'($urandom_range(2, 64)));
		add_random_points(300);
		add_limit(10'd12);
		add_random_points(235);

		@(posedge arst_n);
		while (pending.size() != 0 || start || escape_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("covered %0d points over %0d limit writes: %0d escaped, %0d stayed bounded",
		         points_seen, limits_set, points_seen - points_out, points_out);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Drop the run if it hangs
	initial begin
		#8000000;
		$display("status: fail");
		$finish;
	end

endmodule
